FILE: hw/rtl/thin_multipole_radiation_kick_core_macros.svh
// assertion macros shared by the kick core rtl
`ifndef THIN_MULTIPOLE_RADIATION_KICK_CORE_MACROS_SVH
`define THIN_MULTIPOLE_RADIATION_KICK_CORE_MACROS_SVH

// property that must hold on every clock edge outside reset
`define TMK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define TMK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tmk_pkg.sv
// shared types and constants of the kick core
`timescale 1ns / 1ps
package tmk_pkg;
    localparam int DW = 64;
    localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

    localparam logic [2:0] REG_LEN   = 3'd0;
    localparam logic [2:0] REG_IRHO  = 3'd1;
    localparam logic [2:0] REG_RADC  = 3'd2;
    localparam logic [2:0] REG_SKEWD = 3'd3;
    localparam logic [2:0] REG_NORMD = 3'd4;
    localparam logic [2:0] REG_ORDER = 3'd5;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } unit_ctl_t;

    function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW-1:0] s;
        s = a + b;
        if (a[DW-1] == b[DW-1] && s[DW-1] != a[DW-1])
            s = a[DW-1] ? SMIN : SMAX;
        return s;
    endfunction

    function automatic logic [DW-1:0] sat_sub(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW-1:0] s;
        s = a - b;
        if (a[DW-1] != b[DW-1] && s[DW-1] != a[DW-1])
            s = a[DW-1] ? SMIN : SMAX;
        return s;
    endfunction

    function automatic logic [DW-1:0] halve(input logic [DW-1:0] v);
        return {v[DW-1], v[DW-1:1]};
    endfunction
endpackage

FILE: hw/rtl/thin_multipole_radiation_kick_core.sv
// each accepted track beat yields one result beat; the horner loop runs order times,
// order being highest_order clamped to the table; products and quotients (a zero divisor
// saturates without dividing) run on one multiplier and one divider used in turn by a sequencer
// throughput: no new track beat is taken until the result beat is accepted
// coefficient write beat: no result; one beat is handled at a time
// reset: asynchronous active low; control, config (order to 1) and coefficient tables clear
`timescale 1ns / 1ps
module thin_multipole_radiation_kick_core #(
    parameter int TABLE_DEPTH = 8,
    parameter int FRAC_BITS = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // coef_index, coef_skew, coef_normal, x, px, y, py, dp, path
    input  logic [519:0] s_tdata,
    // command
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // x_out, px_out, y_out, py_out, dp_out, path_out
    output logic [383:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    import tmk_pkg::*;
    `include "thin_multipole_radiation_kick_core_macros.svh"

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

    // register file slots
    localparam logic [4:0] V_X = 5'd0, V_PX = 5'd1, V_Y = 5'd2, V_PY = 5'd3;
    localparam logic [4:0] V_DP = 5'd4, V_PATH = 5'd5, V_OPD = 5'd6, V_XPR = 5'd7;
    localparam logic [4:0] V_YPR = 5'd8, V_RE = 5'd9, V_IM = 5'd10, V_T0 = 5'd11;
    localparam logic [4:0] V_T1 = 5'd12, V_BY = 5'd13, V_H = 5'd14, V_ANG = 5'd15;
    localparam logic [4:0] V_V2 = 5'd16, V_A = 5'd17, V_B = 5'd18, V_C = 5'd19;
    localparam logic [4:0] V_NUM = 5'd20, V_B2P = 5'd21, V_F = 5'd22, V_DPN = 5'd23;
    localparam logic [4:0] V_PXN = 5'd24, V_PYN = 5'd25, V_PATHN = 5'd26, V_K = 5'd27;
    localparam logic [4:0] V_TC = 5'd28, V_OPD2 = 5'd29, V_G = 5'd30, V_ZERO = 5'd31;

    localparam logic [4:0] S_LEN = 5'd0, S_IRHO = 5'd1, S_RADC = 5'd2, S_ONE = 5'd3;
    localparam logic [4:0] S_NORMD = 5'd4, S_SKEWD = 5'd5, S_NTI = 5'd6, S_STI = 5'd7;
    localparam logic [4:0] S_B1 = 5'd8;

    // op kinds
    localparam logic [2:0] OP_MUL = 3'd0, OP_DIV = 3'd1, OP_ADD = 3'd2, OP_SUB = 3'd3;
    localparam logic [2:0] OP_HALF = 3'd4, OP_END = 3'd5, OP_LOOP = 3'd6;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0, ST_FETCH = 3'd1, ST_WAIT = 3'd2;
    localparam logic [2:0] ST_OUT = 3'd3;

    // operand selector: bit 5 picks a special source
    typedef struct packed {
        logic [2:0] op;
        logic [5:0] a;
        logic [5:0] b;
        logic [4:0] d;
    } uop_t;

    localparam logic [5:0] PC_LOOP = 6'd4;
    localparam logic [5:0] PC_POST = 6'd12;

    function automatic uop_t prog(input logic [5:0] pc);
        uop_t u;
        case (pc)
            6'd0: u = '{OP_ADD, {1'b1, S_ONE}, {1'b0, V_DP}, V_OPD};
            6'd1: u = '{OP_DIV, {1'b0, V_PX}, {1'b0, V_OPD}, V_XPR};
            6'd2: u = '{OP_DIV, {1'b0, V_PY}, {1'b0, V_OPD}, V_YPR};
            6'd3: u = '{OP_LOOP, 6'd0, 6'd0, V_ZERO};
            // horner body
            6'd4: u = '{OP_MUL, {1'b0, V_RE}, {1'b0, V_X}, V_T0};
            6'd5: u = '{OP_MUL, {1'b0, V_IM}, {1'b0, V_Y}, V_T1};
            6'd6: u = '{OP_SUB, {1'b0, V_T0}, {1'b0, V_T1}, V_T0};
            6'd7: u = '{OP_MUL, {1'b0, V_IM}, {1'b0, V_X}, V_T1};
            6'd8: u = '{OP_MUL, {1'b0, V_RE}, {1'b0, V_Y}, V_TC};
            6'd9: u = '{OP_ADD, {1'b0, V_T1}, {1'b0, V_TC}, V_T1};
            6'd10: u = '{OP_ADD, {1'b0, V_T0}, {1'b1, S_NTI}, V_RE};
            6'd11: u = '{OP_ADD, {1'b0, V_T1}, {1'b1, S_STI}, V_IM};
            6'd12: u = '{OP_ADD, {1'b0, V_RE}, {1'b1, S_NORMD}, V_RE};
            6'd13: u = '{OP_ADD, {1'b0, V_IM}, {1'b1, S_SKEWD}, V_IM};
            6'd14: u = '{OP_ADD, {1'b0, V_RE}, {1'b1, S_IRHO}, V_BY};
            6'd15: u = '{OP_MUL, {1'b0, V_X}, {1'b1, S_IRHO}, V_G};
            6'd16: u = '{OP_ADD, {1'b1, S_ONE}, {1'b0, V_G}, V_H};
            6'd17: u = '{OP_MUL, {1'b0, V_XPR}, {1'b0, V_XPR}, V_T0};
            6'd18: u = '{OP_MUL, {1'b0, V_YPR}, {1'b0, V_YPR}, V_T1};
            6'd19: u = '{OP_ADD, {1'b0, V_T0}, {1'b0, V_T1}, V_ANG};
            6'd20: u = '{OP_MUL, {1'b0, V_H}, {1'b0, V_H}, V_T0};
            6'd21: u = '{OP_ADD, {1'b0, V_T0}, {1'b0, V_ANG}, V_V2};
            6'd22: u = '{OP_MUL, {1'b0, V_BY}, {1'b0, V_H}, V_A};
            6'd23: u = '{OP_MUL, {1'b0, V_IM}, {1'b0, V_H}, V_B};
            6'd24: u = '{OP_MUL, {1'b0, V_IM}, {1'b0, V_YPR}, V_T0};
            6'd25: u = '{OP_MUL, {1'b0, V_BY}, {1'b0, V_XPR}, V_T1};
            6'd26: u = '{OP_SUB, {1'b0, V_T0}, {1'b0, V_T1}, V_C};
            6'd27: u = '{OP_MUL, {1'b0, V_A}, {1'b0, V_A}, V_T0};
            6'd28: u = '{OP_MUL, {1'b0, V_B}, {1'b0, V_B}, V_T1};
            6'd29: u = '{OP_ADD, {1'b0, V_T0}, {1'b0, V_T1}, V_NUM};
            6'd30: u = '{OP_MUL, {1'b0, V_C}, {1'b0, V_C}, V_T0};
            6'd31: u = '{OP_ADD, {1'b0, V_NUM}, {1'b0, V_T0}, V_NUM};
            6'd32: u = '{OP_DIV, {1'b0, V_NUM}, {1'b0, V_V2}, V_B2P};
            6'd33: u = '{OP_HALF, {1'b0, V_ANG}, {1'b0, V_ZERO}, V_T0};
            6'd34: u = '{OP_ADD, {1'b0, V_H}, {1'b0, V_T0}, V_T0};
            6'd35: u = '{OP_MUL, {1'b0, V_OPD}, {1'b0, V_OPD}, V_T1};
            6'd36: u = '{OP_MUL, {1'b0, V_T0}, {1'b0, V_T1}, V_T0};
            6'd37: u = '{OP_MUL, {1'b0, V_T0}, {1'b1, S_LEN}, V_F};
            6'd38: u = '{OP_MUL, {1'b1, S_RADC}, {1'b0, V_B2P}, V_T0};
            6'd39: u = '{OP_MUL, {1'b0, V_T0}, {1'b0, V_F}, V_T0};
            6'd40: u = '{OP_SUB, {1'b0, V_DP}, {1'b0, V_T0}, V_DPN};
            6'd41: u = '{OP_ADD, {1'b1, S_ONE}, {1'b0, V_DPN}, V_OPD2};
            6'd42: u = '{OP_MUL, {1'b0, V_XPR}, {1'b0, V_OPD2}, V_PXN};
            6'd43: u = '{OP_MUL, {1'b0, V_YPR}, {1'b0, V_OPD2}, V_PYN};
            // kx
            6'd44: u = '{OP_SUB, {1'b0, V_DP}, {1'b0, V_G}, V_T0};
            6'd45: u = '{OP_MUL, {1'b0, V_T0}, {1'b1, S_IRHO}, V_T0};
            6'd46: u = '{OP_SUB, {1'b0, V_RE}, {1'b0, V_T0}, V_K};
            6'd47: u = '{OP_MUL, {1'b1, S_IRHO}, {1'b1, S_B1}, V_TC};
            6'd48: u = '{OP_MUL, {1'b0, V_TC}, {1'b0, V_X}, V_T0};
            6'd49: u = '{OP_MUL, {1'b0, V_T0}, {1'b0, V_Y}, V_T0};
            6'd50: u = '{OP_ADD, {1'b0, V_K}, {1'b0, V_T0}, V_K};
            6'd51: u = '{OP_MUL, {1'b1, S_LEN}, {1'b0, V_K}, V_T0};
            6'd52: u = '{OP_SUB, {1'b0, V_PXN}, {1'b0, V_T0}, V_PXN};
            // ky
            6'd53: u = '{OP_MUL, {1'b0, V_X}, {1'b0, V_X}, V_T0};
            6'd54: u = '{OP_MUL, {1'b0, V_Y}, {1'b0, V_Y}, V_T1};
            6'd55: u = '{OP_HALF, {1'b0, V_T1}, {1'b0, V_ZERO}, V_T1};
            6'd56: u = '{OP_SUB, {1'b0, V_T0}, {1'b0, V_T1}, V_T0};
            6'd57: u = '{OP_MUL, {1'b0, V_TC}, {1'b0, V_T0}, V_T0};
            6'd58: u = '{OP_SUB, {1'b0, V_IM}, {1'b0, V_T0}, V_K};
            6'd59: u = '{OP_MUL, {1'b1, S_LEN}, {1'b0, V_K}, V_T0};
            6'd60: u = '{OP_ADD, {1'b0, V_PYN}, {1'b0, V_T0}, V_PYN};
            6'd61: u = '{OP_MUL, {1'b1, S_LEN}, {1'b1, S_IRHO}, V_T0};
            6'd62: u = '{OP_MUL, {1'b0, V_T0}, {1'b0, V_X}, V_T0};
            6'd63: u = '{OP_ADD, {1'b0, V_PATH}, {1'b0, V_T0}, V_PATHN};
            default: u = '{OP_END, 6'd0, 6'd0, V_ZERO};
        endcase
        return u;
    endfunction

    logic [DW-1:0] len_reg, irho_reg, radc_reg, skewd_reg, normd_reg;
    logic [2:0]    order_reg;
    logic [DW-1:0] ntab_reg [TABLE_DEPTH];
    logic [DW-1:0] stab_reg [TABLE_DEPTH];
    logic [DW-1:0] rf_reg [32];

    logic [2:0]    state_reg;
    logic [5:0]    pc_reg;
    logic [6:0]    pcx;
    logic [AW-1:0] idx_reg;
    logic [383:0]  out_reg;

    uop_t          u;
    logic [DW-1:0] opa, opb, alu;
    logic [AW-1:0] ho;
    logic          mul_start, div_start, mul_done, div_done, div_busy;
    logic [DW-1:0] mul_p, div_q;
    unit_ctl_t     div_ctl;

    function automatic logic [DW-1:0] src(input logic [5:0] s, input logic [DW-1:0] rf,
                                          input logic [DW-1:0] len, input logic [DW-1:0] irho,
                                          input logic [DW-1:0] radc, input logic [DW-1:0] nd,
                                          input logic [DW-1:0] sd, input logic [DW-1:0] nt,
                                          input logic [DW-1:0] st, input logic [DW-1:0] b1);
        logic [DW-1:0] v;
        if (!s[5])
            v = rf;
        else
            case (s[4:0])
                S_LEN: v = len;
                S_IRHO: v = irho;
                S_RADC: v = radc;
                S_ONE: v = ONE;
                S_NORMD: v = nd;
                S_SKEWD: v = sd;
                S_NTI: v = nt;
                S_STI: v = st;
                S_B1: v = b1;
                default: v = '0;
            endcase
        return v;
    endfunction

    assign u = prog(pc_reg);
    assign pcx = {1'b0, pc_reg};
    assign ho = (32'(order_reg) > TABLE_DEPTH - 1) ? AW'(TABLE_DEPTH - 1) : AW'(order_reg);
    assign opa = src(u.a, rf_reg[u.a[4:0]], len_reg, irho_reg, radc_reg, normd_reg, skewd_reg,
                     ntab_reg[idx_reg], stab_reg[idx_reg], ntab_reg[AW'(1)]);
    assign opb = src(u.b, rf_reg[u.b[4:0]], len_reg, irho_reg, radc_reg, normd_reg, skewd_reg,
                     ntab_reg[idx_reg], stab_reg[idx_reg], ntab_reg[AW'(1)]);

    always_comb
    begin
        case (u.op)
            OP_ADD: alu = sat_add(opa, opb);
            OP_SUB: alu = sat_sub(opa, opb);
            OP_HALF: alu = halve(opa);
            default: alu = '0;
        endcase
    end

    assign mul_start = (state_reg == ST_FETCH) && (u.op == OP_MUL);
    assign div_start = (state_reg == ST_FETCH) && (u.op == OP_DIV);
    assign div_ctl = '{start: div_start, busy: div_busy, done: div_done};

    tmk_multiplier #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(opa), .b(opb),
        .done(mul_done), .prod(mul_p)
    );

    tmk_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(opa), .den(opb),
        .busy(div_busy), .done(div_done), .quot(div_q)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg <= '0;
            idx_reg <= '0;
            len_reg <= '0;
            irho_reg <= '0;
            radc_reg <= '0;
            skewd_reg <= '0;
            normd_reg <= '0;
            order_reg <= 3'd1;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                ntab_reg[i] <= '0;
                stab_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_LEN: len_reg <= cfg_data;
                    REG_IRHO: irho_reg <= cfg_data;
                    REG_RADC: radc_reg <= cfg_data;
                    REG_SKEWD: skewd_reg <= cfg_data;
                    REG_NORMD: normd_reg <= cfg_data;
                    REG_ORDER: order_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (!s_tuser)
                        begin
                            if (32'(s_tdata[2:0]) < TABLE_DEPTH)
                            begin
                                stab_reg[AW'(s_tdata[2:0])] <= s_tdata[66:3];
                                ntab_reg[AW'(s_tdata[2:0])] <= s_tdata[130:67];
                            end
                        end
                        else
                        begin
                            state_reg <= ST_FETCH;
                            pc_reg <= '0;
                        end
                    end
                end
                ST_FETCH:
                begin
                    case (u.op)
                        OP_MUL, OP_DIV: state_reg <= ST_WAIT;
                        OP_LOOP:
                        begin
                            idx_reg <= ho - 1'b1;
                            pc_reg <= (ho == '0) ? PC_POST : PC_LOOP;
                        end
                        OP_END: state_reg <= ST_OUT;
                        default:
                        begin
                            if (pc_reg == 6'd11)
                            begin
                                idx_reg <= idx_reg - 1'b1;
                                pc_reg <= (idx_reg == '0) ? PC_POST : PC_LOOP;
                            end
                            else if (pcx == 7'd63)
                                state_reg <= ST_OUT;
                            else
                                pc_reg <= pc_reg + 6'd1;
                        end
                    endcase
                end
                ST_WAIT:
                begin
                    if (mul_done || div_done)
                    begin
                        state_reg <= ST_FETCH;
                        pc_reg <= pc_reg + 6'd1;
                    end
                end
                ST_OUT:
                begin
                    if (m_tready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath register file and result beat
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid && s_tuser)
        begin
            rf_reg[V_X] <= s_tdata[194:131];
            rf_reg[V_PX] <= s_tdata[258:195];
            rf_reg[V_Y] <= s_tdata[322:259];
            rf_reg[V_PY] <= s_tdata[386:323];
            rf_reg[V_DP] <= s_tdata[450:387];
            rf_reg[V_PATH] <= s_tdata[514:451];
            rf_reg[V_ZERO] <= '0;
        end
        else if (state_reg == ST_FETCH && u.op == OP_LOOP)
        begin
            rf_reg[V_RE] <= ntab_reg[ho];
            rf_reg[V_IM] <= stab_reg[ho];
        end
        else if (state_reg == ST_FETCH && (u.op == OP_ADD || u.op == OP_SUB || u.op == OP_HALF))
            rf_reg[u.d] <= alu;
        else if (state_reg == ST_WAIT && mul_done)
            rf_reg[u.d] <= mul_p;
        else if (state_reg == ST_WAIT && div_done)
            rf_reg[u.d] <= div_q;
        if (state_reg == ST_FETCH && pcx == 7'd63)
            out_reg <= {alu, rf_reg[V_DPN], rf_reg[V_PYN], rf_reg[V_Y],
                        rf_reg[V_PXN], rf_reg[V_X]};
    end

    `TMK_ASSERT(a_one_unit, !(mul_start && div_start), "both units started together")
    `TMK_ASSERT(a_div_idle, !(div_ctl.start && div_ctl.busy), "divider restarted while busy")
    `TMK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "beat lost")
endmodule

FILE: hw/rtl/tmk_divider.sv
// restoring fixed point divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tmk_divider #(
    parameter int FRAC_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [tmk_pkg::DW-1:0] num,
    input  logic [tmk_pkg::DW-1:0] den,
    output logic                  busy,
    output logic                  done,
    output logic [tmk_pkg::DW-1:0] quot
);
    import tmk_pkg::*;
    localparam int NW = 2 * DW;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] r_reg, r_next, d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next, busy_reg, busy_next, done_reg, done_next;
    logic [DW-1:0] res_reg, res_next;
    logic [DW-1:0] ma, r_sh;
    logic          carry;

    always_comb
    begin
        n_next = n_reg;
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next = res_reg;
        ma = num[DW-1] ? (~num + 1'b1) : num;
        carry = r_reg[DW-1];
        r_sh = {r_reg[DW-2:0], n_reg[NW-1]};
        if (start)
        begin
            if (den == '0)
            begin
                res_next = (num == '0) ? '0 : (num[DW-1] ? SMIN : SMAX);
                done_next = 1'b1;
            end
            else
            begin
                n_next = {{DW{1'b0}}, ma} << FRAC_BITS;
                d_next = den[DW-1] ? (~den + 1'b1) : den;
                neg_next = num[DW-1] ^ den[DW-1];
                r_next = '0;
                q_next = '0;
                cnt_next = CW'(NW);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[NW-2:0], 1'b0};
            if (carry || r_sh >= d_reg)
            begin
                r_next = r_sh - d_reg;
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (!neg_reg)
                    res_next = (q_next[NW-1:DW] != '0 || q_next[DW-1]) ? SMAX : q_next[DW-1:0];
                else if (q_next[NW-1:DW] != '0 || (q_next[DW-1] && q_next[DW-2:0] != '0))
                    res_next = SMIN;
                else
                    res_next = ~q_next[DW-1:0] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = res_reg;
endmodule

FILE: hw/rtl/tmk_multiplier.sv
// fixed point multiplier, four 32x32 partial products accumulated in turn
`timescale 1ns / 1ps
module tmk_multiplier #(
    parameter int FRAC_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [tmk_pkg::DW-1:0] a,
    input  logic [tmk_pkg::DW-1:0] b,
    output logic                  done,
    output logic [tmk_pkg::DW-1:0] prod
);
    import tmk_pkg::*;
    localparam int HW = DW / 2;
    localparam int PW = 2 * DW;

    logic [DW-1:0] ma_reg, mb_reg;
    logic          neg_reg;
    logic [PW-1:0] acc_reg, acc_next;
    logic [2:0]    step_reg, step_next;
    logic          done_reg, done_next;
    logic [DW-1:0] res_reg, res_next;
    logic [HW-1:0] opa, opb;
    logic [DW-1:0] pp_reg;
    logic [PW-1:0] shifted;
    logic [PW-1:0] q;
    logic          rem_nz;

    always_comb
    begin
        case (step_reg)
            3'd1: begin opa = ma_reg[HW-1:0];  opb = mb_reg[HW-1:0];  end
            3'd2: begin opa = ma_reg[HW-1:0];  opb = mb_reg[DW-1:HW]; end
            3'd3: begin opa = ma_reg[DW-1:HW]; opb = mb_reg[HW-1:0];  end
            default: begin opa = ma_reg[DW-1:HW]; opb = mb_reg[DW-1:HW]; end
        endcase
    end

    always_comb
    begin
        case (step_reg)
            3'd2: shifted = {{DW{1'b0}}, pp_reg};
            3'd3, 3'd4: shifted = {{HW{1'b0}}, pp_reg, {HW{1'b0}}};
            default: shifted = {pp_reg, {DW{1'b0}}};
        endcase
        acc_next = acc_reg;
        step_next = 3'd0;
        done_next = 1'b0;
        res_next = res_reg;
        q = '0;
        rem_nz = 1'b0;
        if (start)
        begin
            acc_next = '0;
            step_next = 3'd1;
        end
        else if (step_reg != 3'd0)
        begin
            if (step_reg >= 3'd2)
                acc_next = acc_reg + shifted;
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd5)
            begin
                step_next = 3'd0;
                done_next = 1'b1;
                q = acc_next >> FRAC_BITS;
                rem_nz = (acc_next & ((PW'(1) << FRAC_BITS) - 1'b1)) != '0;
                if (neg_reg && rem_nz)
                    q = q + 1'b1;
                if (!neg_reg)
                    res_next = (q[PW-1:DW] != '0 || q[DW-1]) ? SMAX : q[DW-1:0];
                else if (q[PW-1:DW] != '0 || (q[DW-1] && q[DW-2:0] != '0))
                    res_next = SMIN;
                else
                    res_next = ~q[DW-1:0] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg <= a[DW-1] ? (~a + 1'b1) : a;
            mb_reg <= b[DW-1] ? (~b + 1'b1) : b;
            neg_reg <= a[DW-1] ^ b[DW-1];
        end
        pp_reg <= opa * opb;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign prod = res_reg;
endmodule
